>>> hw/rtl/ulrc_pkg.sv
package ulrc_pkg;

    // field widths
    localparam int unsigned WIDTH_W    = 8;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned DIST_W     = 24;
    localparam int unsigned LEFT_W     = 6;
    localparam int unsigned PRESCALE_W = 10;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 8'd1;

    // register reset values
    localparam logic [WIDTH_W-1:0]    PULSE_WIDTH_RST = 8'd20;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd1000;

    // timing constants
    localparam logic [WIDTH_W-1:0]    MIN_PULSE    = 8'd10;
    localparam logic [WIDTH_W-1:0]    MAX_PULSE    = 8'd50;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL = 16'd1000;
    localparam logic [PRESCALE_W-1:0] US_PER_MS    = 10'd1000;
    localparam logic [WIDTH_W-1:0]    UM_PER_TICK  = 8'd170;

    typedef logic [LEFT_W-1:0] t_left;

    // trigger pulse width limited to 10..50 us
    function automatic t_left clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] c;
        begin
            if (w < MIN_PULSE) begin
                c = MIN_PULSE;
            end else if (w > MAX_PULSE) begin
                c = MAX_PULSE;
            end else begin
                c = w;
            end
            return c[LEFT_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/ultrasonic_range_controller.sv
// Ultrasonic rangefinder trigger/echo controller. Every input word is one
// microsecond tick and yields exactly one output word; one word is taken per
// clock unless the output stalls, passing an input register and then the
// result register that also updates the timing state. The echo high time is
// counted in ticks and reported on its falling edge as ticks * 170 um,
// saturated at 2^24-1; the tick counter itself saturates at its full scale.
// Trigger pulses are clamped to 10..50 us; periodic mode waits at least
// 1000 ms after each pulse. Configuration registers: index 0 periodic pulse
// width (us), index 1 periodic interval (ms); the config channel is always
// ready and should only be written while no words are in flight.
module ultrasonic_range_controller #(
    parameter int unsigned ECHO_COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_echo_level,
    input  logic                          i_run_periodic,
    input  logic                          i_single_shot,
    input  logic [ulrc_pkg::WIDTH_W-1:0]  i_shot_width_us,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_trigger_level,
    output logic                          o_distance_valid,
    output logic [ulrc_pkg::DIST_W-1:0]   o_distance_um,
    output logic                          o_measuring,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ulrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ulrc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ulrc_pkg::*;

    localparam int unsigned CNT_W  = ECHO_COUNT_BITS;
    localparam int unsigned PROD_W = (CNT_W + WIDTH_W > DIST_W + 1) ?
                                     CNT_W + WIDTH_W : DIST_W + 1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PROD_W-1:0] DIST_MAX = PROD_W'({DIST_W{1'b1}});

    // configuration registers
    logic [WIDTH_W-1:0]    r_pulse_width;
    logic [INTERVAL_W-1:0] r_interval;

    // input stage
    logic                  r_in_vld;
    logic                  r_echo_in;
    logic                  r_run_in;
    logic                  r_shot_in;
    logic [WIDTH_W-1:0]    r_shot_w_in;

    // timing state
    logic                  r_prev_echo,  n_prev_echo;
    logic                  r_echo_busy,  n_echo_busy;
    logic [CNT_W-1:0]      r_echo_ticks, n_echo_ticks;
    logic                  r_pulse_act,  n_pulse_act;
    t_left                 r_pulse_left, n_pulse_left;
    logic [PRESCALE_W-1:0] r_prescale,   n_prescale;
    logic [INTERVAL_W-1:0] r_wait_ms,    n_wait_ms;
    logic                  r_wait_ph,    n_wait_ph;

    // result register
    logic                  r_out_vld;
    logic                  r_trig,  n_trig;
    logic                  r_dvld,  n_dvld;
    logic [DIST_W-1:0]     r_dist,  n_dist;
    logic                  r_meas;

    logic                  advance;
    logic                  take_in;
    logic                  wait_entered;
    logic [PROD_W-1:0]     product;

    // handshake: result register frees when empty or being taken
    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;
    assign take_in    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= PULSE_WIDTH_RST;
            r_interval    <= INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PULSE_WIDTH: r_pulse_width <= i_cfg_data[WIDTH_W-1:0];
                REG_INTERVAL:    r_interval    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_echo_in   <= i_echo_level;
            r_run_in    <= i_run_periodic;
            r_shot_in   <= i_single_shot;
            r_shot_w_in <= i_shot_width_us;
        end
    end

    // distance scaling
    assign product = PROD_W'(r_echo_ticks) * PROD_W'(UM_PER_TICK);

    // one tick of the controller
    always_comb begin
        n_prev_echo  = r_echo_in;
        n_echo_busy  = r_echo_busy;
        n_echo_ticks = r_echo_ticks;
        n_pulse_act  = r_pulse_act;
        n_pulse_left = r_pulse_left;
        n_prescale   = r_prescale;
        n_wait_ms    = r_wait_ms;
        n_wait_ph    = r_wait_ph;
        n_dvld       = 1'b0;
        n_dist       = '0;
        wait_entered = 1'b0;

        // echo timing
        if (r_echo_busy) begin
            if (r_echo_in) begin
                if (r_echo_ticks != CNT_MAX) begin
                    n_echo_ticks = r_echo_ticks + 1'b1;
                end
            end else begin
                n_dist      = (product > DIST_MAX) ? {DIST_W{1'b1}} : product[DIST_W-1:0];
                n_dvld      = 1'b1;
                n_echo_busy = 1'b0;
            end
        end else if (r_echo_in && !r_prev_echo) begin
            n_echo_busy  = 1'b1;
            n_echo_ticks = CNT_W'(1);
        end

        // stopping periodic mode
        if (!r_run_in) begin
            n_wait_ph  = 1'b0;
            n_wait_ms  = '0;
            n_prescale = '0;
        end

        // pulse start, periodic wins over a single shot
        if (!n_pulse_act) begin
            if (r_run_in && !n_wait_ph) begin
                n_pulse_act  = 1'b1;
                n_pulse_left = clamp_width(r_pulse_width);
            end else if (r_shot_in) begin
                n_pulse_act  = 1'b1;
                n_pulse_left = clamp_width(r_shot_w_in);
            end
        end

        // pulse output and end
        n_trig = n_pulse_act;
        if (n_pulse_act) begin
            n_pulse_left = n_pulse_left - 1'b1;
            if (n_pulse_left == '0) begin
                n_pulse_act = 1'b0;
                if (r_run_in && !n_wait_ph) begin
                    n_wait_ph    = 1'b1;
                    n_wait_ms    = (r_interval < MIN_INTERVAL) ? MIN_INTERVAL : r_interval;
                    n_prescale   = '0;
                    wait_entered = 1'b1;
                end
            end
        end

        // periodic wait, millisecond prescaler
        if (n_wait_ph && !wait_entered) begin
            n_prescale = n_prescale + 1'b1;
            if (n_prescale >= US_PER_MS) begin
                n_prescale = '0;
                if (n_wait_ms != '0) begin
                    n_wait_ms = n_wait_ms - 1'b1;
                end
                if (n_wait_ms == '0) begin
                    n_wait_ph = 1'b0;
                end
            end
        end
    end

    // state and result update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_prev_echo  <= 1'b0;
            r_echo_busy  <= 1'b0;
            r_echo_ticks <= '0;
            r_pulse_act  <= 1'b0;
            r_pulse_left <= '0;
            r_prescale   <= '0;
            r_wait_ms    <= '0;
            r_wait_ph    <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_prev_echo  <= n_prev_echo;
                r_echo_busy  <= n_echo_busy;
                r_echo_ticks <= n_echo_ticks;
                r_pulse_act  <= n_pulse_act;
                r_pulse_left <= n_pulse_left;
                r_prescale   <= n_prescale;
                r_wait_ms    <= n_wait_ms;
                r_wait_ph    <= n_wait_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_trig <= n_trig;
            r_dvld <= n_dvld;
            r_dist <= n_dist;
            r_meas <= n_echo_busy;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_trigger_level  = r_trig;
    assign o_distance_valid = r_dvld;
    assign o_distance_um    = r_dist;
    assign o_measuring      = r_meas;

    // checks
    a_pulse_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse_act == (r_pulse_left != '0))
        else $error("pulse counter out of step with active flag");

    a_wait_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait_ph |-> (r_wait_ms != '0))
        else $error("wait phase with no milliseconds left");

    a_prescale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prescale < US_PER_MS)
        else $error("prescaler beyond one millisecond");

    a_busy_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_echo_busy |-> (r_echo_ticks != '0))
        else $error("measurement running with zero ticks");

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_dvld) |-> (r_dist == '0))
        else $error("distance set without a finished measurement");

endmodule

>>> bench/tb_ultrasonic_range_controller.sv
module tb_ultrasonic_range_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ulrc_pkg::*;

    localparam int unsigned ECHO_BITS     = 16;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned SCRIPT_LEN    = 24;
    localparam int unsigned CHUNK_WORDS   = 200;
    // a stretch of periodic running at the shortest settings
    localparam int unsigned PERIOD_WORDS  = 200;
    localparam int unsigned ECHO_WORDS    = 100;

    // spare register indexes, neither decodes to a register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    localparam longint unsigned DIST_TOP = (64'd1 << DIST_W) - 1;

    typedef struct packed {
        logic               echo;
        logic               run;
        logic               shot;
        logic [WIDTH_W-1:0] width;
    } t_tick;

    typedef struct packed {
        logic              trig;
        logic              dvalid;
        logic [DIST_W-1:0] dist_um;
        logic              meas;
    } t_range;

    typedef struct packed {
        t_tick       stim;
        logic [15:0] reps;
        logic        typed;
        t_range      want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_echo_level;
    logic                  i_run_periodic;
    logic                  i_single_shot;
    logic [WIDTH_W-1:0]    i_shot_width_us;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_trigger_level;
    logic                  o_distance_valid;
    logic [DIST_W-1:0]     o_distance_um;
    logic                  o_measuring;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ultrasonic_range_controller #(
        .ECHO_COUNT_BITS(ECHO_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_echo_level    (i_echo_level),
        .i_run_periodic  (i_run_periodic),
        .i_single_shot   (i_single_shot),
        .i_shot_width_us (i_shot_width_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_level (o_trigger_level),
        .o_distance_valid(o_distance_valid),
        .o_distance_um   (o_distance_um),
        .o_measuring     (o_measuring),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ranger model state and its copy of the registers
    logic [WIDTH_W-1:0]    width_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic                  last_echo;
    logic                  timing_echo;
    logic [ECHO_BITS-1:0]  echo_count;
    logic                  pulse_on;
    t_left                 pulse_left;
    logic [PRESCALE_W-1:0] us_count;
    logic [INTERVAL_W-1:0] ms_left;
    logic                  waiting;

    t_range      ranger_due[$];
    t_script_row script[SCRIPT_LEN];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit          hold_req = 1'b0;
    bit          rx_free = 1'b1;
    logic        cur_echo = 1'b0;
    logic        cur_run = 1'b0;

    // trigger width limited to the legal pulse range
    function automatic t_left fit_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] c;
        c = (w < MIN_PULSE) ? MIN_PULSE : ((w > MAX_PULSE) ? MAX_PULSE : w);
        return c[LEFT_W-1:0];
    endfunction

    // one microsecond of the ranger: echo timing, trigger pulse, periodic wait
    function automatic t_range advance_ranger(input t_tick t);
        t_range          r;
        logic            entered;
        longint unsigned prod;
        r = '0;
        entered = 1'b0;
        if (timing_echo) begin
            if (t.echo) begin
                if (echo_count != {ECHO_BITS{1'b1}}) echo_count = echo_count + 1'b1;
            end else begin
                prod = 64'(echo_count) * 64'(UM_PER_TICK);
                r.dist_um = (prod > DIST_TOP) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];
                r.dvalid = 1'b1;
                timing_echo = 1'b0;
            end
        end else if (t.echo && !last_echo) begin
            timing_echo = 1'b1;
            echo_count = ECHO_BITS'(1);
        end
        last_echo = t.echo;

        if (!t.run) begin
            waiting = 1'b0;
            ms_left = '0;
            us_count = '0;
        end

        if (!pulse_on) begin
            if (t.run && !waiting) begin
                pulse_on = 1'b1;
                pulse_left = fit_width(width_reg);
            end else if (t.shot) begin
                pulse_on = 1'b1;
                pulse_left = fit_width(t.width);
            end
        end

        r.trig = pulse_on;
        if (pulse_on) begin
            pulse_left = pulse_left - 1'b1;
            if (pulse_left == '0) begin
                pulse_on = 1'b0;
                if (t.run && !waiting) begin
                    waiting = 1'b1;
                    ms_left = (interval_reg < MIN_INTERVAL) ? MIN_INTERVAL : interval_reg;
                    us_count = '0;
                    entered = 1'b1;
                end
            end
        end

        if (waiting && !entered) begin
            us_count = us_count + 1'b1;
            if (us_count >= US_PER_MS) begin
                us_count = '0;
                if (ms_left != '0) ms_left = ms_left - 1'b1;
                if (ms_left == '0) waiting = 1'b0;
            end
        end

        r.meas = timing_echo;
        return r;
    endfunction

    function automatic t_script_row row(input logic e, input logic r, input logic s,
                                        input logic [WIDTH_W-1:0] w, input int n,
                                        input bit typed, input logic tg, input logic dv,
                                        input logic [DIST_W-1:0] d, input logic m);
        t_script_row x;
        x.stim = '{echo: e, run: r, shot: s, width: w};
        x.reps = n[15:0];
        x.typed = typed;
        x.want = '{trig: tg, dvalid: dv, dist_um: d, meas: m};
        return x;
    endfunction

    // well-formed echo pulses and run stretches, with some one-tick noise
    function automatic t_tick draw_tick(input bit hold_run);
        t_tick t;
        if ($urandom_range(0, 11) == 0) cur_echo = !cur_echo;
        if (hold_run) begin
            cur_run = 1'b1;
        end else if ($urandom_range(0, 59) == 0) begin
            cur_run = !cur_run;
        end
        t.echo = cur_echo;
        t.run = cur_run;
        if (!hold_run && $urandom_range(0, 19) == 0) begin
            t.echo = 1'($urandom_range(0, 1));
            t.run = 1'($urandom_range(0, 1));
        end
        t.shot = ($urandom_range(0, 6) == 0);
        t.width = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(6, 56));
        return t;
    endfunction

    // offer one tick word and hold it until taken
    task automatic push_tick(input t_tick t, input bit typed, input t_range want);
        t_range got;
        i_in_valid <= 1'b1;
        i_echo_level <= t.echo;
        i_run_periodic <= t.run;
        i_single_shot <= t.shot;
        i_shot_width_us <= t.width;
        do @(posedge i_clk); while (o_in_stall);
        got = advance_ranger(t);
        ranger_due.push_back(typed ? want : got);
    endtask

    // stop offering and wait until every expected word is back
    task automatic drain;
        i_in_valid <= 1'b0;
        while (ranger_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_PULSE_WIDTH: width_reg = data[WIDTH_W-1:0];
            REG_INTERVAL:    interval_reg = data[INTERVAL_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_fault(input string what, input t_range want, input t_range seen);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("%s: trig %0b/%0b valid %0b/%0b dist %0d/%0d meas %0b/%0b (exp/act)",
                     what, want.trig, seen.trig, want.dvalid, seen.dvalid,
                     want.dist_um, seen.dist_um, want.meas, seen.meas);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_range seen;
        t_range want;
        seen = '{trig: o_trigger_level, dvalid: o_distance_valid,
                 dist_um: o_distance_um, meas: o_measuring};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ranger_due.size() == 0) begin
                note_fault("unexpected word", '0, seen);
            end else begin
                want = ranger_due.pop_front();
                if (seen.trig !== want.trig || seen.dvalid !== want.dvalid ||
                    seen.dist_um !== want.dist_um || seen.meas !== want.meas) begin
                    note_fault("mismatch", want, seen);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_ultrasonic_range_controller NOT OK");
            $finish;
        end
    end

    // receiver: random stall runs, one long hold on request
    initial begin
        bit stalling;
        int run_left;
        stalling = 1'b0;
        run_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_free) begin
                i_out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 25);
                    if (!stalling && $urandom_range(0, 7) == 0) run_left = 120;
                end
                run_left--;
                i_out_stall <= stalling;
            end
        end
    end

    // stimulus
    initial begin
        int     burst;
        int     gap;
        t_tick  t;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_echo_level <= 1'b0;
        i_run_periodic <= 1'b0;
        i_single_shot <= 1'b0;
        i_shot_width_us <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;

        width_reg = PULSE_WIDTH_RST;
        interval_reg = INTERVAL_RST;
        last_echo = 1'b0;
        timing_echo = 1'b0;
        echo_count = '0;
        pulse_on = 1'b0;
        pulse_left = '0;
        us_count = '0;
        ms_left = '0;
        waiting = 1'b0;

        // directed script: echo, run, shot, width, repeats, then typed result
        script[0]  = row(1, 0, 0, 8'd0,   1,  TYPED, 0, 0, 24'd0, 1); // echo high out of reset
        script[1]  = row(1, 0, 0, 8'd0,   3,  PRED,  0, 0, 24'd0, 0);
        script[2]  = row(0, 0, 0, 8'd0,   1,  TYPED, 0, 1, 24'd680, 0);
        script[3]  = row(0, 0, 1, 8'd0,   1,  TYPED, 1, 0, 24'd0, 0); // width below minimum
        script[4]  = row(0, 0, 1, 8'd255, 1,  PRED,  0, 0, 24'd0, 0); // shot while busy
        script[5]  = row(0, 0, 0, 8'd0,   12, PRED,  0, 0, 24'd0, 0);
        script[6]  = row(0, 0, 1, 8'd255, 1,  TYPED, 1, 0, 24'd0, 0); // width above maximum
        script[7]  = row(0, 0, 0, 8'd0,   55, PRED,  0, 0, 24'd0, 0);
        script[8]  = row(0, 0, 1, 8'd10,  1,  PRED,  0, 0, 24'd0, 0);
        script[9]  = row(1, 0, 0, 8'd0,   12, PRED,  0, 0, 24'd0, 0);
        script[10] = row(0, 0, 1, 8'd30,  60, PRED,  0, 0, 24'd0, 0); // back-to-back shots
        script[11] = row(0, 1, 1, 8'd33,  1,  TYPED, 1, 0, 24'd0, 0); // periodic beats shot
        script[12] = row(0, 1, 0, 8'd0,   25, PRED,  0, 0, 24'd0, 0);
        script[13] = row(0, 1, 1, 8'd15,  1,  TYPED, 1, 0, 24'd0, 0); // shot during wait
        script[14] = row(1, 1, 0, 8'd0,   30, PRED,  0, 0, 24'd0, 0);
        script[15] = row(0, 1, 1, 8'd0,   1,  PRED,  0, 0, 24'd0, 0);
        script[16] = row(1, 0, 0, 8'd0,   1,  PRED,  0, 0, 24'd0, 0); // stop clears wait
        script[17] = row(0, 1, 0, 8'd0,   15, PRED,  0, 0, 24'd0, 0);
        script[18] = row(1, 0, 0, 8'd0,   30, PRED,  0, 0, 24'd0, 0); // stop mid-pulse
        script[19] = row(0, 0, 0, 8'd0,   1,  PRED,  0, 0, 24'd0, 0);
        script[20] = row(1, 0, 0, 8'd0,   1,  PRED,  0, 0, 24'd0, 0); // shortest echo
        script[21] = row(0, 0, 0, 8'd0,   1,  PRED,  0, 0, 24'd0, 0);
        script[22] = row(1, 0, 0, 8'd0,   1,  PRED,  0, 0, 24'd0, 0);
        script[23] = row(0, 0, 0, 8'd0,   2,  PRED,  0, 0, 24'd0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at reset settings
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            for (int k = 0; k < script[i].reps; k++) begin
                push_tick(script[i].stim, script[i].typed, script[i].want);
            end
        end
        drain();

        // shortest period; upper data bits and spare indexes must be ignored
        write_reg(REG_PULSE_WIDTH, 16'hAB00);
        write_reg(REG_INTERVAL, 16'h0000);
        write_reg(REG_SPARE, 16'($urandom));
        write_reg(REG_TOP, 16'hFFFF);
        for (int i = 0; i < PERIOD_WORDS; i++) begin
            push_tick(draw_tick(1'b1), PRED, '0);
        end
        drain();

        // widest settings, then a longer echo
        write_reg(REG_PULSE_WIDTH, 16'h00FF);
        write_reg(REG_INTERVAL, 16'hFFFF);
        t = '{echo: 1'b0, run: 1'b0, shot: 1'b0, width: 8'd0};
        push_tick(t, PRED, '0);
        t.echo = 1'b1;
        for (int i = 0; i < ECHO_WORDS; i++) push_tick(t, PRED, '0);
        t.echo = 1'b0;
        push_tick(t, TYPED, '{trig: 1'b0, dvalid: 1'b1, dist_um: 24'd17000, meas: 1'b0});
        t.run = 1'b1;
        for (int i = 0; i < 60; i++) push_tick(t, PRED, '0);
        t.run = 1'b0;
        push_tick(t, PRED, '0);
        drain();

        // random words in bursts, several settings, each chunk drained
        rx_free = 1'b0;
        cur_echo = 1'b0;
        cur_run = 1'b0;
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: begin
                    write_reg(REG_PULSE_WIDTH, 16'($urandom));
                    write_reg(REG_INTERVAL, 16'($urandom));
                end
                1: begin
                    write_reg(REG_PULSE_WIDTH, 16'd10);
                    write_reg(REG_INTERVAL, 16'd1000);
                end
                2: begin
                    write_reg(REG_PULSE_WIDTH, 16'd50);
                    write_reg(REG_INTERVAL, 16'd999);
                end
                default: begin
                    write_reg(REG_PULSE_WIDTH, 16'($urandom_range(0, 60)));
                    write_reg(REG_INTERVAL, 16'($urandom_range(0, 2000)));
                end
            endcase
            // long receiver hold while words keep coming
            if (chunk == 1) hold_req = 1'b1;
            burst = $urandom_range(1, 40);
            for (int i = 0; i < CHUNK_WORDS; i++) begin
                push_tick(draw_tick(1'b0), PRED, '0);
                burst--;
                if (burst == 0) begin
                    gap = $urandom_range(0, 6);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst = $urandom_range(1, 40);
                end
            end
            drain();
        end

        if (fault_count == 0 && ranger_due.size() == 0) begin
            $display("tb_ultrasonic_range_controller OK");
        end else begin
            $display("tb_ultrasonic_range_controller NOT OK");
        end
        $finish;
    end

endmodule
